>>> src/i2ctbe_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the I2C target bit engine.
// Depends on nothing; every other file of the block imports it.
package i2ctbe_pkg;

  typedef enum logic [1:0] {
    BUS_READY  = 2'd0,
    BUS_RUN    = 2'd1,
    BUS_STOP   = 2'd2,
    BUS_RSTART = 2'd3
  } bus_mode_t;

  typedef enum logic [2:0] {
    ENG_IDLE  = 3'd0,
    ENG_START = 3'd1,
    ENG_RX    = 3'd2,
    ENG_TX    = 3'd3,
    ENG_ACK   = 3'd4
  } engine_mode_t;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_RECV = 2'd1,
    OP_SEND = 2'd2,
    OP_ACK  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_START   = 3'd1,
    EV_STOP    = 3'd2,
    EV_RSTART  = 3'd3,
    EV_RXDONE  = 3'd4,
    EV_TXDONE  = 3'd5,
    EV_ACKDONE = 3'd6
  } event_t;

  // Bits are handled MSB first, so every byte starts at this position.
  localparam logic [2:0] TOP_BIT = 3'd7;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    op_t        op;
    logic [7:0] tx_byte;
  } in_word_t;

  typedef struct packed {
    logic       sda_drive_low;
    logic [7:0] rx_byte;
    event_t     event_res;
    logic       busy_res;
    bus_mode_t  bus_state;
  } out_word_t;

  typedef struct packed {
    bus_mode_t    bus_mode;
    engine_mode_t engine_mode;
    phase_t       phase;
    logic [2:0]   bit_position;
    logic [7:0]   shift_byte;
    logic         last_sampled_bit;
    logic [7:0]   send_byte;
    logic         drive_low;
  } engine_state_t;

endpackage

>>> src/i2c_target_bit_engine_unit.sv
`timescale 1ns / 1ps
// Top level of the I2C target bit engine: state register, step logic, output buffer.
// Depends on i2ctbe_pkg, i2ctbe_step and i2ctbe_out_buf.
//
// This block takes one sampled SCL/SDA word per clock, together with an optional
// command (receive a byte, send a byte or send an ACK), and returns exactly one
// result word for each word it accepts: the SDA drive, the byte shifted in so far,
// an event code, a busy flag and the bus state. It sustains one word per clock
// cycle while out_stall is low. Through the step logic each accepted word updates
// the state at the edge that accepts it; its result is registered at that edge,
// in the output register or, while that is held, in the skid entry. A two-entry
// output buffer lets the block keep accepting while a finished result waits to
// be taken; in_stall rises only once both entries are occupied, and it is driven
// from a register. Address matching and the sequencing of commands are left to
// the surrounding logic, and the caller is expected to feed the pin samples in
// order without gaps in the sense of the bus: every accepted word is one tick.
module i2c_target_bit_engine_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  i2ctbe_pkg::in_word_t  in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output i2ctbe_pkg::out_word_t out_word
);
  import i2ctbe_pkg::*;

  engine_state_t st;
  engine_state_t st_next;
  out_word_t     res;
  logic          push;

  // A word is taken whenever the buffer has room for its result.
  assign push = in_valid && !in_stall;

  // The step logic computes the new state and the result word in one pass.
  i2ctbe_step u_step (
    .st      (st),
    .in_word (in_word),
    .st_next (st_next),
    .res     (res)
  );

  // Engine state advances only on accepted words, so stalls leave it untouched.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.bus_mode         <= BUS_READY;
      st.engine_mode      <= ENG_IDLE;
      st.phase            <= PH_FIRST;
      st.bit_position     <= TOP_BIT;
      st.shift_byte       <= 8'd0;
      st.last_sampled_bit <= 1'b0;
      st.send_byte        <= 8'd0;
      st.drive_low        <= 1'b0;
    end else if (push) begin
      st <= st_next;
    end
  end

  // The output register and its skid entry decouple the two handshakes.
  i2ctbe_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

`ifndef NO_ASSERTIONS
  // The skid entry is only ever filled behind a valid output register.
  assert property (@(posedge clk) disable iff (rst) in_stall |-> out_valid)
    else $error("skid entry occupied while output register is empty");

  // The engine never holds SDA low while it has no operation in progress.
  assert property (@(posedge clk) disable iff (rst)
    (st.engine_mode == ENG_IDLE) |-> !st.drive_low)
    else $error("SDA held low while engine idle");

  // A completed START always leaves the bus running.
  assert property (@(posedge clk) disable iff (rst)
    (push && res.event_res == EV_START) |-> (res.bus_state == BUS_RUN))
    else $error("START reported without bus running");

  // A word taken into an empty buffer shows up at the output next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (push && !out_valid) |=> out_valid)
    else $error("accepted word did not reach the output register");
`endif

endmodule

>>> src/i2ctbe_step.sv
`timescale 1ns / 1ps
// Single-tick update of the bit engine: next state and result word.
// Depends on i2ctbe_pkg.
module i2ctbe_step (
  input  i2ctbe_pkg::engine_state_t st,
  input  i2ctbe_pkg::in_word_t      in_word,
  output i2ctbe_pkg::engine_state_t st_next,
  output i2ctbe_pkg::out_word_t     res
);
  import i2ctbe_pkg::*;

  engine_state_t n;
  event_t        ev;

  // Next state: the idle stage clears STOP, may take a command or spot START, then the
  // engine acts on the same sample in whatever mode it is now in.
  always_comb begin : next_state
    n  = st;
    ev = EV_NONE;

    if (n.engine_mode == ENG_IDLE) begin
      if (n.bus_mode == BUS_STOP) begin
        n.bus_mode = BUS_READY;
      end
      if (in_word.op != OP_NONE) begin
        if (n.bus_mode == BUS_RSTART) begin
          n.bus_mode = BUS_RUN;
        end
        n.phase        = PH_FIRST;
        n.bit_position = TOP_BIT;
        unique case (in_word.op)
          OP_RECV: begin
            n.engine_mode = ENG_RX;
            n.shift_byte  = 8'd0;
          end
          OP_SEND: begin
            n.engine_mode = ENG_TX;
            n.send_byte   = in_word.tx_byte;
          end
          OP_ACK: begin
            n.engine_mode = ENG_ACK;
            n.drive_low   = 1'b1;
          end
          default: ;
        endcase
      end else if (n.bus_mode == BUS_READY && !in_word.sda_level && in_word.scl_level) begin
        n.engine_mode = ENG_START;
      end
    end

    unique case (n.engine_mode)
      ENG_START: begin
        if (!in_word.scl_level) begin
          n.bus_mode    = BUS_RUN;
          ev            = EV_START;
          n.engine_mode = ENG_IDLE;
        end
      end
      ENG_RX: begin
        case (n.phase)
          PH_FIRST: begin
            if (in_word.scl_level) begin
              n.last_sampled_bit = in_word.sda_level;
              if (in_word.sda_level) begin
                n.shift_byte[n.bit_position] = 1'b1;
              end
              n.phase = PH_SECOND;
            end
          end
          PH_SECOND: begin
            if (in_word.scl_level) begin
              // SDA moving while SCL is high is a STOP or a repeated START.
              if (!n.last_sampled_bit && in_word.sda_level) begin
                n.bus_mode    = BUS_STOP;
                ev            = EV_STOP;
                n.engine_mode = ENG_IDLE;
                n.phase       = PH_FIRST;
              end else if (n.last_sampled_bit && !in_word.sda_level) begin
                n.bus_mode = BUS_RSTART;
                n.phase    = PH_THIRD;
              end
            end else if (n.bit_position == 3'd0) begin
              ev            = EV_RXDONE;
              n.engine_mode = ENG_IDLE;
              n.phase       = PH_FIRST;
            end else begin
              n.bit_position = n.bit_position - 3'd1;
              n.phase        = PH_FIRST;
            end
          end
          default: begin
            if (!in_word.scl_level) begin
              ev            = EV_RSTART;
              n.engine_mode = ENG_IDLE;
              n.phase       = PH_FIRST;
            end
          end
        endcase
      end
      ENG_TX: begin
        case (n.phase)
          PH_FIRST: begin
            if (!in_word.scl_level) begin
              n.drive_low = !n.send_byte[n.bit_position];
              n.phase     = PH_SECOND;
            end
          end
          PH_SECOND: begin
            if (in_word.scl_level) begin
              n.phase = PH_THIRD;
            end
          end
          default: begin
            if (!in_word.scl_level) begin
              n.drive_low = 1'b0;
              if (n.bit_position == 3'd0) begin
                ev            = EV_TXDONE;
                n.engine_mode = ENG_IDLE;
                n.phase       = PH_FIRST;
              end else begin
                n.bit_position = n.bit_position - 3'd1;
                n.drive_low    = !n.send_byte[n.bit_position];
                n.phase        = PH_SECOND;
              end
            end
          end
        endcase
      end
      ENG_ACK: begin
        if (n.phase == PH_FIRST) begin
          if (in_word.scl_level) begin
            n.phase = PH_SECOND;
          end
        end else if (!in_word.scl_level) begin
          n.drive_low   = 1'b0;
          ev            = EV_ACKDONE;
          n.engine_mode = ENG_IDLE;
          n.phase       = PH_FIRST;
        end
      end
      default: ;
    endcase
  end

  assign st_next = n;

  // Result word, taken from the state after this tick's update.
  always_comb begin : outputs
    res.sda_drive_low = n.drive_low;
    res.rx_byte       = n.shift_byte;
    res.event_res     = ev;
    res.busy_res      = (n.engine_mode != ENG_IDLE);
    res.bus_state     = n.bus_mode;
  end

endmodule

>>> src/i2ctbe_out_buf.sv
`timescale 1ns / 1ps
// Two-entry output buffer: an output register backed by a skid register.
// Depends on i2ctbe_pkg.
module i2ctbe_out_buf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  i2ctbe_pkg::out_word_t push_word,
  output logic                  full,
  output logic                  out_valid,
  input  logic                  out_stall,
  output i2ctbe_pkg::out_word_t out_word
);
  import i2ctbe_pkg::*;

  out_word_t skid_word;
  logic      skid_valid;
  logic      pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_word <= skid_word;
        if (push) begin
          skid_word <= push_word;
        end else begin
          skid_valid <= 1'b0;
        end
      end else begin
        out_valid <= push;
        out_word  <= push_word;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_word  <= push_word;
        skid_valid <= 1'b1;
      end else begin
        out_word  <= push_word;
        out_valid <= 1'b1;
      end
    end
  end

endmodule
